@@ hdl/dcfs_pkg.sv @@
package dcfs_pkg;

  localparam int DEF_CLIENT_SLOTS = 3;
  localparam int DEF_LAYER_COUNT  = 3;
  localparam int DEF_LIST_DEPTH   = 48;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam logic [15:0] FRAME_PERIOD_RESET = 16'd33;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic REG_FRAME_PERIOD = 1'b0;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_COMMIT,
    OP_READ,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_DROPPED,
    STATUS_NO_SLOT,
    STATUS_COMMITTED
  } status_e;

  typedef enum logic {
    BACK_EXEC,
    BACK_RESP
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] pid;
    logic [7:0]  layer;
    logic [63:0] payload;
    logic [1:0]  slot;
    logic [5:0]  entry_index;
    logic [31:0] now_ms;
  } queue_item_t;

endpackage

@@ hdl/dcfs_front.sv @@
module dcfs_front #(
  parameter int LAYER_COUNT = dcfs_pkg::DEF_LAYER_COUNT
) (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            func_i,
  input  logic [31:0]           client_pid_i,
  input  logic [7:0]            layer_i,
  input  logic                  is_present_i,
  input  logic [63:0]           payload_i,
  input  logic [1:0]            slot_i,
  input  logic [5:0]            entry_index_i,
  input  logic [31:0]           now_ms_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output dcfs_pkg::queue_item_t q_item_o
);
  import dcfs_pkg::*;

  op_e        op;
  logic [7:0] layer_clamped;

  always_comb begin
    unique case (func_i)
      FUNC_SUBMIT: op = is_present_i ? OP_COMMIT : OP_APPEND;
      FUNC_READ:   op = OP_READ;
      FUNC_TICK:   op = OP_TICK;
      default:     op = OP_NOP;
    endcase
  end

  assign layer_clamped = (int'(layer_i) >= LAYER_COUNT) ? 8'(LAYER_COUNT - 1) : layer_i;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.op          = op;
    q_item_o.pid         = client_pid_i;
    q_item_o.layer       = layer_clamped;
    q_item_o.payload     = payload_i;
    q_item_o.slot        = slot_i;
    q_item_o.entry_index = entry_index_i;
    q_item_o.now_ms      = now_ms_i;
  end

endmodule

@@ hdl/dcfs_queue.sv @@
module dcfs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dcfs_pkg::queue_item_t item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output dcfs_pkg::queue_item_t item_o
);
  import dcfs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t       entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (int'(count_q) == QUEUE_DEPTH);
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hdl/dcfs_back.sv @@
module dcfs_back #(
  parameter int CLIENT_SLOTS = dcfs_pkg::DEF_CLIENT_SLOTS,
  parameter int LAYER_COUNT  = dcfs_pkg::DEF_LAYER_COUNT,
  parameter int LIST_DEPTH   = dcfs_pkg::DEF_LIST_DEPTH,
  parameter int PAYLOAD_BITS = dcfs_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           frame_period_i,
  input  logic                  q_valid_i,
  input  dcfs_pkg::queue_item_t q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dcfs_pkg::status_e     status_o,
  output logic [1:0]            client_slot_o,
  output logic [63:0]           entry_payload_o,
  output logic [5:0]            entry_count_o,
  output logic                  entry_valid_o,
  output logic                  redraw_fire_o,
  output logic                  redraw_pending_o
);
  import dcfs_pkg::*;

  localparam int SLOT_W      = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int LISTS       = CLIENT_SLOTS * LAYER_COUNT;
  localparam int LIST_W      = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int STORE_DEPTH = LISTS * 2 * LIST_DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [CLIENT_SLOTS-1:0] used_q;
  logic [31:0]             pid_q    [CLIENT_SLOTS];
  logic [LISTS-1:0]        bank_q;
  logic [LISTS-1:0]        open_q;
  logic [CNT_W-1:0]        pcount_q [LISTS];
  logic [CNT_W-1:0]        ccount_q [LISTS];
  logic                    redraw_q, redraw_d;
  logic [31:0]             last_q;

  logic [PAYLOAD_BITS-1:0] store_mem [STORE_DEPTH];
  logic [PAYLOAD_BITS-1:0] rdata_q;
  logic                    rd_valid_q;
  logic [5:0]              rd_count_q;

  back_state_e state_q, state_d;

  logic        out_valid_q, out_valid_d;
  status_e     status_q;
  logic [1:0]  cslot_q;
  logic [63:0] epay_q;
  logic [5:0]  ecount_q;
  logic        evalid_q;
  logic        fire_q;
  logic        pending_q;

  logic              hit, free_any;
  logic [SLOT_W-1:0] hit_idx, free_idx, sub_slot, rd_slot, cur_slot;
  logic              slot_ok, rd_slot_ok;
  logic [LIST_W-1:0] list;
  logic              bank, pbank, open;
  logic [CNT_W-1:0]  pcnt, ccnt, base_cnt;
  logic              room, rd_hit;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [31:0]       elapsed;
  logic              tick_fire;
  logic              go, load;
  logic              is_submit;
  logic              do_claim, do_commit, do_append, mem_we, do_fire;

  status_e     res_status;
  logic [1:0]  res_cslot;

  always_comb begin
    hit      = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < CLIENT_SLOTS; i++) begin
      if (!hit && used_q[i] && (pid_q[i] == q_item_i.pid)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!free_any && !used_q[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign sub_slot   = hit ? hit_idx : free_idx;
  assign slot_ok    = hit || free_any;
  assign rd_slot    = SLOT_W'(q_item_i.slot);
  assign rd_slot_ok = (int'(q_item_i.slot) < CLIENT_SLOTS) && used_q[rd_slot];
  assign cur_slot   = (q_item_i.op == OP_READ) ? rd_slot : sub_slot;

  assign list     = LIST_W'(int'(cur_slot) * LAYER_COUNT + int'(q_item_i.layer));
  assign bank     = bank_q[list];
  assign pbank    = ~bank;
  assign open     = open_q[list];
  assign pcnt     = pcount_q[list];
  assign ccnt     = ccount_q[list];
  assign base_cnt = open ? pcnt : '0;
  assign room     = int'(base_cnt) < LIST_DEPTH;
  assign rd_hit   = int'(q_item_i.entry_index) < int'(ccnt);

  assign wr_addr = ADDR_W'((int'(list) * 2 + int'(pbank)) * LIST_DEPTH + int'(base_cnt));
  assign rd_addr = ADDR_W'((int'(list) * 2 + int'(bank)) * LIST_DEPTH
                           + int'(q_item_i.entry_index));

  assign elapsed   = q_item_i.now_ms - last_q;
  assign tick_fire = redraw_q && ((last_q == '0) || (elapsed >= {16'b0, frame_period_i}));

  assign go        = (state_q == BACK_EXEC) && q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o   = go;
  assign is_submit = (q_item_i.op == OP_APPEND) || (q_item_i.op == OP_COMMIT);
  assign do_claim  = go && is_submit && !hit && free_any;
  assign do_commit = go && (q_item_i.op == OP_COMMIT) && slot_ok;
  assign do_append = go && (q_item_i.op == OP_APPEND) && slot_ok;
  assign mem_we    = do_append && room;
  assign do_fire   = go && (q_item_i.op == OP_TICK) && tick_fire;

  always_comb begin
    redraw_d = redraw_q;
    if (do_commit) begin
      redraw_d = 1'b1;
    end else if (do_fire) begin
      redraw_d = 1'b0;
    end
  end

  always_comb begin
    res_status = STATUS_OK;
    res_cslot  = '0;
    if (is_submit) begin
      if (!slot_ok) begin
        res_status = STATUS_NO_SLOT;
      end else begin
        res_cslot = 2'(sub_slot);
        if (q_item_i.op == OP_COMMIT) begin
          res_status = STATUS_COMMITTED;
        end else if (!room) begin
          res_status = STATUS_DROPPED;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BACK_EXEC: begin
        if (go && (q_item_i.op == OP_READ)) begin
          state_d = BACK_RESP;
        end
      end
      BACK_RESP: state_d = BACK_EXEC;
      default:   state_d = BACK_EXEC;
    endcase
  end

  assign load = (go && (q_item_i.op != OP_READ)) || (state_q == BACK_RESP);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_EXEC;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      bank_q      <= '0;
      open_q      <= '0;
      redraw_q    <= 1'b0;
      last_q      <= '0;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        pid_q[i] <= '0;
      end
      for (int j = 0; j < LISTS; j++) begin
        pcount_q[j] <= '0;
        ccount_q[j] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      redraw_q    <= redraw_d;
      if (do_claim) begin
        used_q[free_idx] <= 1'b1;
        pid_q[free_idx]  <= q_item_i.pid;
      end
      if (do_commit) begin
        bank_q[list]   <= pbank;
        ccount_q[list] <= pcnt;
        pcount_q[list] <= '0;
        open_q[list]   <= 1'b0;
      end
      if (do_append) begin
        open_q[list]   <= 1'b1;
        pcount_q[list] <= room ? base_cnt + 1'b1 : base_cnt;
      end
      if (do_fire) begin
        last_q <= q_item_i.now_ms;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[wr_addr] <= q_item_i.payload[PAYLOAD_BITS-1:0];
    end
    rdata_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (go && (q_item_i.op == OP_READ)) begin
      rd_valid_q <= rd_slot_ok && rd_hit;
      rd_count_q <= rd_slot_ok ? 6'(ccnt) : '0;
    end
    if (state_q == BACK_RESP) begin
      status_q  <= STATUS_OK;
      cslot_q   <= '0;
      epay_q    <= rd_valid_q ? 64'(rdata_q) : '0;
      ecount_q  <= rd_count_q;
      evalid_q  <= rd_valid_q;
      fire_q    <= 1'b0;
      pending_q <= redraw_q;
    end else if (load) begin
      status_q  <= res_status;
      cslot_q   <= res_cslot;
      epay_q    <= '0;
      ecount_q  <= '0;
      evalid_q  <= 1'b0;
      fire_q    <= do_fire;
      pending_q <= redraw_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign client_slot_o    = cslot_q;
  assign entry_payload_o  = epay_q;
  assign entry_count_o    = ecount_q;
  assign entry_valid_o    = evalid_q;
  assign redraw_fire_o    = fire_q;
  assign redraw_pending_o = pending_q;

endmodule

@@ hdl/draw_command_frame_store_top.sv @@
// A submit, tick or unused item's result is registered when the back end takes it from
// the queue; a read item's result passes first through the registered store read and
// the response state. Submit and tick items: 1 item per cycle while the output is not
// stalled; a read holds the response state for the store read, so the next item waits.
// Reset: asynchronous, active low; clears slots, counts, banks, redraw state and the
// frame period (to 33). The command store is not cleared; no clearing pass.
module draw_command_frame_store_top #(
  parameter int CLIENT_SLOTS = dcfs_pkg::DEF_CLIENT_SLOTS,
  parameter int LAYER_COUNT  = dcfs_pkg::DEF_LAYER_COUNT,
  parameter int LIST_DEPTH   = dcfs_pkg::DEF_LIST_DEPTH,
  parameter int PAYLOAD_BITS = dcfs_pkg::DEF_PAYLOAD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] client_pid_i,
  input  logic [7:0]  layer_i,
  input  logic        is_present_i,
  input  logic [63:0] payload_i,
  input  logic [1:0]  slot_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  client_slot_o,
  output logic [63:0] entry_payload_o,
  output logic [5:0]  entry_count_o,
  output logic        entry_valid_o,
  output logic        redraw_fire_o,
  output logic        redraw_pending_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcfs_pkg::*;

  logic [15:0] frame_period_q;
  logic        q_full, q_push, q_valid, q_pop;
  queue_item_t push_item, head_item;
  status_e     status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_PERIOD) ? {16'b0, frame_period_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q <= FRAME_PERIOD_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FRAME_PERIOD)) begin
      frame_period_q <= pwdata[15:0];
    end
  end

  dcfs_front #(
    .LAYER_COUNT(LAYER_COUNT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .client_pid_i (client_pid_i),
    .layer_i      (layer_i),
    .is_present_i (is_present_i),
    .payload_i    (payload_i),
    .slot_i       (slot_i),
    .entry_index_i(entry_index_i),
    .now_ms_i     (now_ms_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  dcfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (head_item)
  );

  dcfs_back #(
    .CLIENT_SLOTS(CLIENT_SLOTS),
    .LAYER_COUNT (LAYER_COUNT),
    .LIST_DEPTH  (LIST_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_period_i  (frame_period_q),
    .q_valid_i       (q_valid),
    .q_item_i        (head_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status),
    .client_slot_o   (client_slot_o),
    .entry_payload_o (entry_payload_o),
    .entry_count_o   (entry_count_o),
    .entry_valid_o   (entry_valid_o),
    .redraw_fire_o   (redraw_fire_o),
    .redraw_pending_o(redraw_pending_o)
  );

  assign status_o = status;

endmodule

@@ hdl/dcfs_checker.sv @@
module dcfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] entry_payload_o,
  input logic        redraw_fire_o,
  input logic        redraw_pending_o
);
  import dcfs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(entry_payload_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_fire_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && redraw_fire_o |-> !redraw_pending_o)
    else $error("redraw still pending after fire");

  a_commit_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_e'(status_o) == STATUS_COMMITTED) |-> redraw_pending_o)
    else $error("commit without redraw pending");

endmodule

bind draw_command_frame_store_top dcfs_checker u_checker (.*);
